>>> src/swmr_pkg.sv
// ----------------------------------------------------------------------------
// swmr_pkg
// Shared constants and types for the sliding window min range block.
// ----------------------------------------------------------------------------
package swmr_pkg;

   localparam int unsigned WINDOW_MAX = 64;
   localparam int unsigned DATA_BITS  = 32;
   localparam int unsigned LEN_BITS   = 7;
   localparam int unsigned SEEN_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int unsigned CNT_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   typedef logic [DATA_BITS-1:0] data_type;
   typedef logic [LEN_BITS-1:0]  len_type;
   typedef logic [SEEN_BITS-1:0] seen_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   // scan token walking down the chain of cells
   typedef struct packed {
      logic    active;
      cnt_type count;
      data_type lo;
      data_type hi;
   } token_type;

   // result of the cell where the scan ends
   typedef struct packed {
      logic     done;
      data_type lo;
      data_type hi;
   } result_type;

endpackage

>>> src/swmr_if.sv
// ----------------------------------------------------------------------------
// swmr interfaces
// Valid/ready channels for sample items, result items and the length register.
// ----------------------------------------------------------------------------
interface swmr_req_if;
   logic               valid;
   logic               ready;
   swmr_pkg::data_type sample;
   logic               last_sample;

   modport source (output valid, sample, last_sample, input ready);
   modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface swmr_rsp_if;
   logic               valid;
   logic               ready;
   swmr_pkg::data_type window_range;
   logic               window_valid;
   swmr_pkg::data_type best_range;
   logic               best_valid;
   logic               sequence_done;

   modport source (output valid, window_range, window_valid, best_range, best_valid,
                   sequence_done, input ready);
   modport sink   (input valid, window_range, window_valid, best_range, best_valid,
                   sequence_done, output ready);
endinterface

interface swmr_csr_if;
   logic              valid;
   logic              ready;
   swmr_pkg::len_type window_length;

   modport source (output valid, window_length, input ready);
   modport sink   (input valid, window_length, output ready);
endinterface

>>> src/swmr_cell.sv
// ----------------------------------------------------------------------------
// swmr_cell
// One window cell: holds a sample, folds it into a passing scan token.
// ----------------------------------------------------------------------------
module swmr_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  swmr_pkg::data_type   sample_in,
   output swmr_pkg::data_type   sample_out,
   input  swmr_pkg::token_type  token_in,
   output swmr_pkg::token_type  token_out,
   output swmr_pkg::result_type result
);

   swmr_pkg::data_type  sample_ff;
   swmr_pkg::token_type token_ff;
   swmr_pkg::data_type  lo_cur;
   swmr_pkg::data_type  hi_cur;
   logic                last_hop;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_in;
      end
      if (reset) begin
         token_ff.active <= 1'b0;
      end else begin
         token_ff <= token_in;
      end
   end

   always_comb begin
      lo_cur   = (sample_ff < token_ff.lo) ? sample_ff : token_ff.lo;
      hi_cur   = (sample_ff > token_ff.hi) ? sample_ff : token_ff.hi;
      last_hop = token_ff.active && (token_ff.count == '0);

      token_out.active = token_ff.active && (token_ff.count != '0);
      token_out.count  = token_ff.count - swmr_pkg::cnt_type'(1);
      token_out.lo     = lo_cur;
      token_out.hi     = hi_cur;

      result.done = last_hop;
      result.lo   = last_hop ? lo_cur : '0;
      result.hi   = last_hop ? hi_cur : '0;
   end

   assign sample_out = sample_ff;

endmodule

>>> src/swmr_chain.sv
// ----------------------------------------------------------------------------
// swmr_chain
// Row of window cells: samples shift in at cell 0, the scan token walks
// towards the far end and the finishing cell reports min and max.
// ----------------------------------------------------------------------------
module swmr_chain (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  swmr_pkg::data_type   sample_in,
   input  swmr_pkg::token_type  start,
   output swmr_pkg::result_type result
);

   swmr_pkg::data_type   sample_q [swmr_pkg::WINDOW_MAX];
   swmr_pkg::token_type  token_q  [swmr_pkg::WINDOW_MAX];
   swmr_pkg::result_type cell_res [swmr_pkg::WINDOW_MAX];

   for (genvar i = 0; i < swmr_pkg::WINDOW_MAX; i++) begin : g_cell
      if (i == 0) begin : g_head
         swmr_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (shift_en),
            .sample_in  (sample_in),
            .sample_out (sample_q[i]),
            .token_in   (start),
            .token_out  (token_q[i]),
            .result     (cell_res[i])
         );
      end else begin : g_body
         swmr_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (shift_en),
            .sample_in  (sample_q[i-1]),
            .sample_out (sample_q[i]),
            .token_in   (token_q[i-1]),
            .token_out  (token_q[i]),
            .result     (cell_res[i])
         );
      end
   end

   // at most one cell finishes, its fields are zero elsewhere
   always_comb begin
      result = '0;
      for (int i = 0; i < swmr_pkg::WINDOW_MAX; i++) begin
         result = result | cell_res[i];
      end
   end

endmodule

>>> src/sliding_window_min_range_top.sv
// ----------------------------------------------------------------------------
// sliding_window_min_range_top
// Smallest max-minus-min range over sliding windows of a sample stream.
// ----------------------------------------------------------------------------
// req_ch carries one sample per item with last_sample marking sequence end.
// rsp_ch returns one item per sample: the range of the window ending there,
// the best (smallest) range of the sequence so far, their valid flags and
// sequence_done. csr_ch writes window_length (0 acts as 1, above 64 as 64);
// write it only while no item is in flight.
// An item that closes a window runs the scan, where the scan token visits
// one cell of the chain per cycle, then S_DIFF forms the range and S_DONE
// loads the result register before the next accept. An item with no full
// window yet goes from accept straight to S_DONE.
// One item is worked on at a time; the next is accepted while the previous
// result still waits in the output register. If the receiver stalls, the
// block holds its finished item until that register frees.
// Reset empties the block, sets window_length to 1 and starts a new
// sequence; after an item with last_sample the sequence state clears too.
// ----------------------------------------------------------------------------
module sliding_window_min_range_top (
   input  logic         clock,
   input  logic         reset,
   swmr_req_if.sink     req_ch,
   swmr_rsp_if.source   rsp_ch,
   swmr_csr_if.sink     csr_ch
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DIFF,
      S_DONE
   } state_type;

   state_type            state_ff,      state_in;
   swmr_pkg::len_type    len_cfg_ff,    len_cfg_in;
   swmr_pkg::seen_type   seen_ff,       seen_in;
   swmr_pkg::data_type   best_ff,       best_in;
   logic                 best_seen_ff,  best_seen_in;
   logic                 last_ff,       last_in;
   logic                 win_ok_ff,     win_ok_in;
   swmr_pkg::data_type   lo_ff,         lo_in;
   swmr_pkg::data_type   hi_ff,         hi_in;
   swmr_pkg::data_type   range_ff,      range_in;
   logic                 rsp_valid_ff,  rsp_valid_in;
   swmr_pkg::data_type   rsp_window_ff, rsp_window_in;
   logic                 rsp_wvalid_ff, rsp_wvalid_in;
   swmr_pkg::data_type   rsp_best_ff,   rsp_best_in;
   logic                 rsp_bvalid_ff, rsp_bvalid_in;
   logic                 rsp_done_ff,   rsp_done_in;

   swmr_pkg::seen_type   len_eff;
   swmr_pkg::seen_type   seen_inc;
   logic                 win_now;
   logic                 accept;
   logic                 slot_free;
   logic                 take_best;
   swmr_pkg::data_type   best_new;
   logic                 shift_en;
   swmr_pkg::token_type  start;
   swmr_pkg::result_type chain_res;

   swmr_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (shift_en),
      .sample_in (req_ch.sample),
      .start     (start),
      .result    (chain_res)
   );

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.window_range  = rsp_window_ff;
   assign rsp_ch.window_valid  = rsp_wvalid_ff;
   assign rsp_ch.best_range    = rsp_best_ff;
   assign rsp_ch.best_valid    = rsp_bvalid_ff;
   assign rsp_ch.sequence_done = rsp_done_ff;

   always_comb begin
      if (len_cfg_ff == '0) begin
         len_eff = swmr_pkg::seen_type'(1);
      end else if (int'(len_cfg_ff) > int'(swmr_pkg::WINDOW_MAX)) begin
         len_eff = swmr_pkg::seen_type'(swmr_pkg::WINDOW_MAX);
      end else begin
         len_eff = swmr_pkg::seen_type'(len_cfg_ff);
      end
      if (int'(seen_ff) < int'(swmr_pkg::WINDOW_MAX)) begin
         seen_inc = seen_ff + swmr_pkg::seen_type'(1);
      end else begin
         seen_inc = seen_ff;
      end
      win_now   = (seen_inc >= len_eff);
      accept    = req_ch.valid && (state_ff == S_IDLE);
      slot_free = !rsp_valid_ff || rsp_ch.ready;
      take_best = win_ok_ff && (!best_seen_ff || (range_ff < best_ff));
      best_new  = take_best ? range_ff : best_ff;

      shift_en     = accept;
      start.active = accept && win_now;
      start.count  = swmr_pkg::cnt_type'(len_eff - swmr_pkg::seen_type'(1));
      start.lo     = '1;
      start.hi     = '0;
   end

   always_comb begin
      state_in      = state_ff;
      len_cfg_in    = len_cfg_ff;
      seen_in       = seen_ff;
      best_in       = best_ff;
      best_seen_in  = best_seen_ff;
      last_in       = last_ff;
      win_ok_in     = win_ok_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      range_in      = range_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_window_in = rsp_window_ff;
      rsp_wvalid_in = rsp_wvalid_ff;
      rsp_best_in   = rsp_best_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_done_in   = rsp_done_ff;

      if (csr_ch.valid) begin
         len_cfg_in = csr_ch.window_length;
      end
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               seen_in   = seen_inc;
               last_in   = req_ch.last_sample;
               win_ok_in = win_now;
               range_in  = '0;
               state_in  = win_now ? S_SCAN : S_DONE;
            end
         end
         S_SCAN: begin
            if (chain_res.done) begin
               lo_in    = chain_res.lo;
               hi_in    = chain_res.hi;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            range_in = hi_ff - lo_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_window_in = range_ff;
               rsp_wvalid_in = win_ok_ff;
               rsp_best_in   = best_new;
               rsp_bvalid_in = best_seen_ff || take_best;
               rsp_done_in   = last_ff;
               if (last_ff) begin
                  seen_in      = '0;
                  best_in      = '0;
                  best_seen_in = 1'b0;
               end else begin
                  best_in      = best_new;
                  best_seen_in = best_seen_ff || take_best;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_cfg_ff   <= swmr_pkg::len_type'(1);
         seen_ff      <= '0;
         best_ff      <= '0;
         best_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_cfg_ff   <= len_cfg_in;
         seen_ff      <= seen_in;
         best_ff      <= best_in;
         best_seen_ff <= best_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff       <= last_in;
      win_ok_ff     <= win_ok_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      range_ff      <= range_in;
      rsp_window_ff <= rsp_window_in;
      rsp_wvalid_ff <= rsp_wvalid_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_done_ff   <= rsp_done_in;
   end

   a_done_in_scan : assert property (@(posedge clock) disable iff (reset)
      chain_res.done |-> (state_ff == S_SCAN))
      else $error("scan finished outside the scan state");

   a_scan_has_window : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (win_ok_ff && (seen_ff >= len_eff)))
      else $error("scan running without a full window");

   a_lo_below_hi : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIFF) |-> (lo_ff <= hi_ff))
      else $error("window minimum above maximum");

   a_sequence_clear : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && slot_free && last_ff)
         |=> ((seen_ff == '0) && !best_seen_ff))
      else $error("sequence state not cleared after last item");

endmodule
